[hdl/bf3_pkg.sv]
`default_nettype none

package bf3_pkg;

  // Pixel and result widths.
  localparam int PIX_W      = 8;
  // Configuration register widths.
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  // Row counter width and the largest meaningful frame height.
  localparam int ROW_W        = 12;
  localparam int HEIGHT_LIMIT = 4095;
  // Smallest frame dimension and the first row/column with a full window.
  localparam int MIN_DIM  = 3;
  localparam int WIN_EDGE = 2;
  // Column sum of three pixels and window sum of nine pixels.
  localparam int COL_SUM_W = 10;
  localparam int WIN_SUM_W = 12;
  // Division by nine as a multiplication by round(2^16 / 9), exact for sums up to 2295.
  localparam int                 RECIP_W   = 13;
  localparam logic [RECIP_W-1:0] RECIP_9   = 13'd7282;
  localparam int                 DIV_SHIFT = 16;
  localparam int                 PROD_W    = WIN_SUM_W + RECIP_W;

  localparam logic [FW_W-1:0] FW_RESET = 11'd800;
  localparam logic [FH_W-1:0] FH_RESET = 12'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // One column of the window, top to bottom, with its sum.
  typedef struct packed {
    logic [PIX_W-1:0]     top;
    logic [PIX_W-1:0]     mid;
    logic [PIX_W-1:0]     bot;
    logic [COL_SUM_W-1:0] sum;
  } column_t;

endpackage

`default_nettype wire

[hdl/bf3_cell.sv]
`default_nettype none

// One window column: holds a column, passes it on to the next cell on each
// shift and adds its column sum to the window sum flowing through the chain.
module bf3_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           shift_en,
  input  wire bf3_pkg::column_t               col_in,
  output      bf3_pkg::column_t               col_out,
  input  wire logic [bf3_pkg::WIN_SUM_W-1:0]  acc_in,
  output      logic [bf3_pkg::WIN_SUM_W-1:0]  acc_out
);
  import bf3_pkg::*;

  column_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;
  assign acc_out = acc_in + WIN_SUM_W'(col_r.sum);

endmodule

`default_nettype wire

[hdl/box_filter_3x3_core.sv]
`default_nettype none

// Streaming 3x3 box filter for 8-bit grayscale frames.
// Pixels arrive in raster order on the in_ channel (in_valid/in_ready/in_pixel).
// Each pixel that completes a full 3x3 window (row 2 or later and column 2 or
// later) yields one request on the out_ channel: the truncated mean of the nine
// pixels centred one row and one column back, with out_frame_end set on the
// last result of a frame. Border pixels yield nothing.
// The cfg_ channel writes frame_width (index 0) and frame_height (index 1); it
// is always ready and should only be used while the filter is idle. Values out
// of range are clamped into 3..MAX_WIDTH and 3..4095.
// Throughput is one pixel per cycle while the skid register is empty. On the
// way to the out_ port, the line store read is registered with the pixel at
// the accepting edge, the window sum through the chain of column cells is
// registered in stage 2, and the multiply by the reciprocal of nine is
// registered in the output register.
// Reset is synchronous: it returns the position to the first pixel of a frame,
// empties the pipeline and restores 800 x 600. The line stores are not cleared.
// When the receiver stalls, one further result is caught in a skid register and
// in_ready then drops until the stall clears, so nothing is lost.
module box_filter_3x3_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Pixel input.
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [bf3_pkg::PIX_W-1:0]       in_pixel,
  // Filter result.
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [bf3_pkg::PIX_W-1:0]       out_mean_value,
  output      logic                            out_frame_end,
  // Configuration writes.
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bf3_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bf3_pkg::*;

  // Column index width, width of a count up to MAX_WIDTH, and a width that
  // also holds the frame_width register for comparisons.
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int WW    = (CNT_W > FW_W) ? CNT_W : FW_W;
  localparam int RW    = ROW_W + 1;

  localparam logic [WW-1:0] W_MIN = WW'(MIN_DIM);
  localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
  localparam logic [RW-1:0] H_MIN = RW'(MIN_DIM);
  localparam logic [RW-1:0] H_MAX = RW'(HEIGHT_LIMIT);

  // Configuration registers.
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  // Position of the next pixel in the frame.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Stage 1: pixel and line store read data.
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic [PIX_W-1:0] upper_rd_r;
  logic [PIX_W-1:0] middle_rd_r;

  // Stage 2: window sum.
  logic                 s2_valid_r;
  logic [WIN_SUM_W-1:0] s2_sum_r;
  logic                 s2_last_r;

  // Output register and skid register.
  logic             out_valid_r;
  logic [PIX_W-1:0] out_mean_r;
  logic             out_last_r;
  logic             skid_valid_r;
  logic [PIX_W-1:0] skid_mean_r;
  logic             skid_last_r;

  // Line stores: rows r-2 and r-1.
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [WW-1:0]        width_eff;
  logic [RW-1:0]        height_eff;
  logic [WW-1:0]        col_ext;
  logic [WW-1:0]        col_inc;
  logic [RW-1:0]        row_ext;
  logic [RW-1:0]        row_inc;
  logic                 in_accept;
  logic                 pipe_en;
  logic                 s1_adv;
  logic                 emit;
  logic                 last;
  column_t              new_col;
  column_t              cell0_col;
  column_t              cell1_col;
  logic [WIN_SUM_W-1:0] acc0;
  logic [WIN_SUM_W-1:0] acc1;
  logic [WIN_SUM_W-1:0] win_sum;
  logic [PROD_W-1:0]    prod;
  logic [PIX_W-1:0]     mean;

  // The whole pipeline moves together; it only halts when the skid register
  // is occupied, so in_ready never depends on out_ready in the same cycle.
  assign pipe_en   = !skid_valid_r;
  assign in_ready  = pipe_en;
  assign in_accept = in_valid && in_ready;
  assign s1_adv    = pipe_en && s1_valid_r;
  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configured frame size into its meaningful range.
  always_comb begin
    if (WW'(frame_width_r) < W_MIN) begin
      width_eff = W_MIN;
    end else if (WW'(frame_width_r) > W_MAX) begin
      width_eff = W_MAX;
    end else begin
      width_eff = WW'(frame_width_r);
    end
    if (RW'(frame_height_r) < H_MIN) begin
      height_eff = H_MIN;
    end else if (RW'(frame_height_r) > H_MAX) begin
      height_eff = H_MAX;
    end else begin
      height_eff = RW'(frame_height_r);
    end
  end

  // Raster position, the window-complete test and the end-of-frame test.
  always_comb begin
    col_ext = WW'(col_r);
    col_inc = col_ext + WW'(1);
    row_ext = RW'(row_r);
    row_inc = row_ext + RW'(1);
    emit    = (row_ext >= RW'(WIN_EDGE)) && (col_ext >= WW'(WIN_EDGE));
    last    = (row_inc == height_eff) && (col_inc == width_eff);
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= width_eff) begin
      col_nxt = '0;
      if (row_inc >= height_eff) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[ROW_W-1:0];
      end
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store reads are issued as the pixel is accepted. The write for a
  // column happens when its pixel leaves stage 1, well before the same column
  // of the next row is read.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      upper_rd_r <= upper_mem[col_r];
    end
    if (s1_adv) begin
      upper_mem[s1_col_r] <= middle_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      middle_rd_r <= middle_mem[col_r];
    end
    if (s1_adv) begin
      middle_mem[s1_col_r] <= s1_pixel_r;
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_pixel_r <= in_pixel;
      s1_col_r   <= col_r;
      s1_emit_r  <= emit;
      s1_last_r  <= last;
    end
  end

  // The newest column comes from the line stores and the incoming pixel.
  always_comb begin
    new_col.top = upper_rd_r;
    new_col.mid = middle_rd_r;
    new_col.bot = s1_pixel_r;
    new_col.sum = COL_SUM_W'(upper_rd_r) + COL_SUM_W'(middle_rd_r)
                + COL_SUM_W'(s1_pixel_r);
  end

  // Two column cells hold columns c-1 and c-2; the window sum accumulates
  // through them.
  assign acc0 = WIN_SUM_W'(new_col.sum);

  bf3_cell u_cell0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_adv),
    .col_in   (new_col),
    .col_out  (cell0_col),
    .acc_in   (acc0),
    .acc_out  (acc1)
  );

  bf3_cell u_cell1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_adv),
    .col_in   (cell0_col),
    .col_out  (cell1_col),
    .acc_in   (acc1),
    .acc_out  (win_sum)
  );

  // Stage 2 registers; only pixels that complete a window become results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_sum_r  <= win_sum;
      s2_last_r <= s1_last_r;
    end
  end

  // Truncated division by nine.
  assign prod = PROD_W'(s2_sum_r) * PROD_W'(RECIP_9);
  assign mean = prod[DIV_SHIFT +: PIX_W];

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s2_valid_r;
    end else if (s2_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_mean_r <= skid_mean_r;
        out_last_r <= skid_last_r;
      end
    end else if (!out_valid_r || out_ready) begin
      out_mean_r <= mean;
      out_last_r <= s2_last_r;
    end else begin
      skid_mean_r <= mean;
      skid_last_r <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;
  assign out_frame_end  = out_last_r;

endmodule

`default_nettype wire

[hdl/bf3_checker.sv]
`default_nettype none

module bf3_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [bf3_pkg::PIX_W-1:0]  out_mean_value,
  input wire logic                       out_frame_end
);
  import bf3_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mean_value) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // Reset empties the pipeline and opens the input.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // The input only closes after the receiver refused a result.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input closed without an output stall");

endmodule

bind box_filter_3x3_core bf3_checker u_bf3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_mean_value (out_mean_value),
  .out_frame_end  (out_frame_end)
);

`default_nettype wire

[bench/box_filter_3x3_core_test.sv]
`timescale 1ns / 100ps

// Self-checking bench for the streaming 3x3 box filter.
//
// Every pixel that the filter takes is also run through a behavioural copy of
// the filter held in this module. That copy has its own line rows, window
// columns, raster position and frame size registers. Whenever it says that a
// pixel completes a full window, the expected mean and frame-end flag are
// queued. Each request on the result channel is then checked, field by field,
// against the oldest queued entry.
module box_filter_3x3_core_test;
  import bf3_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int WINDOW_CELLS  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             frame_end;
  } filter_result_t;

  // One row of the directed stimulus. Where typed is set, the mean and flag of
  // the row are the result that this pixel must produce. Otherwise the
  // behavioural filter decides.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             typed;
    logic [PIX_W-1:0] mean;
    logic             frame_end;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_mean_value;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // State of the behavioural filter.
  logic [PIX_W-1:0] row_above2 [MAX_W];
  logic [PIX_W-1:0] row_above1 [MAX_W];
  logic [PIX_W-1:0] older_column [3];
  logic [PIX_W-1:0] newer_column [3];
  int unsigned      cur_col;
  int unsigned      cur_row;
  logic [FW_W-1:0]  frame_w_reg;
  logic [FH_W-1:0]  frame_h_reg;

  // Means still owed by the filter, oldest first.
  filter_result_t pending_means [$];
  filter_result_t oldest_mean;

  int          mismatches = 0;
  int          sent_pixels = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // A long receiver hold-off is asked for by bumping hold_asked; the receiver
  // process notices the change and counts the hold-off down itself.
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  // Three 3x3 frames. The first two are flat, so their single mean can be read
  // off directly; the third mixes extreme and middling values and is left to
  // the behavioural filter.
  directed_row_t directed_rows [27] = '{
    '{8'hFF, 1'b0, 8'h00, 1'b0}, '{8'hFF, 1'b0, 8'h00, 1'b0}, '{8'hFF, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 8'h00, 1'b0}, '{8'hFF, 1'b0, 8'h00, 1'b0}, '{8'hFF, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 8'h00, 1'b0}, '{8'hFF, 1'b0, 8'h00, 1'b0}, '{8'hFF, 1'b1, 8'hFF, 1'b1},
    '{8'h00, 1'b0, 8'h00, 1'b0}, '{8'h00, 1'b0, 8'h00, 1'b0}, '{8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 8'h00, 1'b0}, '{8'h00, 1'b0, 8'h00, 1'b0}, '{8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 8'h00, 1'b0}, '{8'h00, 1'b0, 8'h00, 1'b0}, '{8'h00, 1'b1, 8'h00, 1'b1},
    '{8'h01, 1'b0, 8'h00, 1'b0}, '{8'h80, 1'b0, 8'h00, 1'b0}, '{8'hFE, 1'b0, 8'h00, 1'b0},
    '{8'h7F, 1'b0, 8'h00, 1'b0}, '{8'h55, 1'b0, 8'h00, 1'b0}, '{8'hAA, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 8'h00, 1'b0}, '{8'hFF, 1'b0, 8'h00, 1'b0}, '{8'h09, 1'b0, 8'h00, 1'b0}
  };

  box_filter_3x3_core #(
    .MAX_WIDTH(MAX_W)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mean_value(out_mean_value),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Guard against a hung handshake, with a wide margin over the slowest
  // legal run.
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Frame size as the filter actually uses it: both registers saturate into
  // their meaningful ranges.
  function automatic int unsigned line_length();
    if (frame_w_reg < MIN_DIM) return MIN_DIM;
    if (frame_w_reg > MAX_W) return MAX_W;
    return frame_w_reg;
  endfunction

  function automatic int unsigned frame_rows();
    if (frame_h_reg < MIN_DIM) return MIN_DIM;
    if (frame_h_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return frame_h_reg;
  endfunction

  // Advances the behavioural filter by one pixel. Returns 1 when the pixel
  // completes a full window, with the truncated mean and frame-end flag.
  function automatic bit filter_pixel(input logic [PIX_W-1:0] pix,
                                      output filter_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned slot;
    int unsigned total;
    logic [PIX_W-1:0] above2;
    logic [PIX_W-1:0] above1;
    bit full_window;
    w = line_length();
    h = frame_rows();
    slot = cur_col % MAX_W;
    above2 = row_above2[slot];
    above1 = row_above1[slot];
    total = above2 + above1 + pix;
    for (int k = 0; k < 3; k++) total += older_column[k] + newer_column[k];
    row_above2[slot] = above1;
    row_above1[slot] = pix;
    older_column = newer_column;
    newer_column[0] = above2;
    newer_column[1] = above1;
    newer_column[2] = pix;
    full_window = (cur_row >= WIN_EDGE) && (cur_col >= WIN_EDGE);
    res.mean = PIX_W'(total / WINDOW_CELLS);
    res.frame_end = (cur_row == h - 1) && (cur_col == w - 1);
    if (cur_col + 1 >= w) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
    return full_window;
  endfunction

  // Offers one pixel, after a random gap when the sender is idling, and runs
  // it through the behavioural filter once the request is taken. Called and
  // returning at a rising edge; valid stays high across back-to-back pixels.
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                            input filter_result_t typed_res);
    filter_result_t res;
    bit produces;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    produces = filter_pixel(pix, res);
    if (typed) pending_means.insert(pending_means.size(), typed_res);
    else if (produces) pending_means.insert(pending_means.size(), res);
    sent_pixels++;
  endtask

  // Writes one register. When more is set, the request stays up for the next
  // write so that valid is never dropped and raised in the same step.
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FRAME_WIDTH) frame_w_reg = data[FW_W-1:0];
    else frame_h_reg = data[FH_W-1:0];
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Frame size changes are made only between frames with the filter idle:
  // every owed mean has come back and the pipeline has had time to settle.
  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w_data,
                                input logic [CFG_DATA_W-1:0] h_data);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(CFG_FRAME_WIDTH, w_data, 1'b1);
    cfg_write(CFG_FRAME_HEIGHT, h_data, 1'b0);
  endtask

  // One whole frame at the current size. Black and white pixels are made
  // more likely so that saturated windows turn up regularly.
  task automatic stream_frame();
    int unsigned n;
    logic [PIX_W-1:0] pix;
    n = line_length() * frame_rows();
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       pix = '0;
        1:       pix = '1;
        default: pix = PIX_W'($urandom_range(255));
      endcase
      push_pixel(pix, 1'b0, '0);
    end
  endtask

  // Complete frames of random small sizes until roughly budget pixels have
  // gone in. Some sizes fall below the minimum and must saturate to three,
  // and some width writes carry a stray top bit that the register drops.
  task automatic run_random_frames(input int budget);
    int start;
    logic [CFG_DATA_W-1:0] w_data;
    logic [CFG_DATA_W-1:0] h_data;
    start = sent_pixels;
    while (sent_pixels - start < budget) begin
      case ($urandom_range(7))
        0:       w_data = CFG_DATA_W'($urandom_range(2));
        1:       w_data = 12'h800 | CFG_DATA_W'($urandom_range(3, 12));
        default: w_data = CFG_DATA_W'($urandom_range(3, 14));
      endcase
      if ($urandom_range(7) == 0) h_data = CFG_DATA_W'($urandom_range(2));
      else h_data = CFG_DATA_W'($urandom_range(3, 9));
      set_frame_size(w_data, h_data);
      stream_frame();
    end
  endtask

  task automatic report(input string what, input int want, input int got);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  // The receiver stalls at random according to recv_idle_pct, except while a
  // long hold-off is running, when it refuses every request.
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each accepted result must match the oldest owed mean in both fields.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        report("no result (unrequested mean)", -1, out_mean_value);
      end else begin
        oldest_mean = pending_means.pop_front();
        if (out_mean_value !== oldest_mean.mean)
          report("mean_value", oldest_mean.mean, out_mean_value);
        if (out_frame_end !== oldest_mean.frame_end)
          report("frame_end", oldest_mean.frame_end, out_frame_end);
      end
    end
  end

  initial begin
    filter_result_t typed_res;
    int wait_left;
    for (int i = 0; i < MAX_W; i++) begin
      row_above2[i] = '0;
      row_above1[i] = '0;
    end
    older_column = '{default: '0};
    newer_column = '{default: '0};
    cur_col = 0;
    cur_row = 0;
    frame_w_reg = FW_RESET;
    frame_h_reg = FH_RESET;

    // First stretch: the sender idles a little, the receiver a lot.
    send_idle_pct = 28;
    recv_idle_pct = 79;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at 3 x 3, reached by writing sizes below the minimum.
    set_frame_size(12'd0, 12'd2);
    for (int i = 0; i < 27; i++) begin
      typed_res.mean = directed_rows[i].mean;
      typed_res.frame_end = directed_rows[i].frame_end;
      push_pixel(directed_rows[i].pixel, directed_rows[i].typed, typed_res);
    end
    run_random_frames(400);

    // Second stretch: the sender idles a lot, the receiver a little.
    send_idle_pct = 79;
    recv_idle_pct = 28;
    run_random_frames(400);

    // Last stretch: neither side idles. A small frame starts under a long
    // receiver hold-off, so the filter fills up and must hold off its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_frame_size(12'd5, 12'd4);
    hold_asked++;
    stream_frame();
    run_random_frames(400);

    in_valid <= 1'b0;
    wait_left = DRAIN_LIMIT;
    while (pending_means.size() != 0 && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    if (pending_means.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected means never arrived", $time, pending_means.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bf3_pkg.sv
hdl/bf3_cell.sv
hdl/box_filter_3x3_core.sv
hdl/bf3_checker.sv
bench/box_filter_3x3_core_test.sv
